[hw/rtl/clle_pkg.sv]
package clle_pkg;

	localparam logic [1:0] FUNC_INS_HEAD = 2'd0;
	localparam logic [1:0] FUNC_INS_TAIL = 2'd1;
	localparam logic [1:0] FUNC_SEARCH   = 2'd2;
	localparam logic [1:0] FUNC_TRAVERSE = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic        ok;
		logic [31:0] item_value;
		logic        last;
	} out_item_t;

	function automatic logic is_nan(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	function automatic logic float_eq(input logic [31:0] a, input logic [31:0] b);
		logic r;
		if (is_nan(a) || is_nan(b)) begin
			r = 1'b0;
		end else if (((a | b) & 32'h7FFF_FFFF) == 32'd0) begin
			r = 1'b1;
		end else begin
			r = (a == b);
		end
		return r;
	endfunction

endpackage

[hw/rtl/clle_front.sv]
// Command queue: holds accepted items until the list engine takes them.
module clle_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  clle_pkg::in_item_t din,
	output logic               cmd_valid,
	input  logic               cmd_take,
	output clle_pkg::in_item_t cmd
);
	import clle_pkg::*;

	in_item_t   buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q[1];
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			buf_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (cmd_take && cmd_valid) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push && !full} - {1'b0, cmd_take && cmd_valid};
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count overflow");
	a_nopop: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_valid |-> (wp_q == rp_q))
		else $error("pointers differ while empty");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (wp_q == rp_q))
		else $error("pointers differ while full");
endmodule

[hw/rtl/clle_back.sv]
// List engine: one slot visit per cycle while the output queue has space; results go to a 2-entry output queue.
module clle_back #(
	parameter int CAPACITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_take,
	input  clle_pkg::in_item_t  cmd,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [4:0]          cfg_data,
	output logic                empty,
	input  logic                pop,
	output clle_pkg::out_item_t dout
);
	import clle_pkg::*;

	localparam int IW = $clog2(CAPACITY + 1);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [31:0]   val_mem [CAPACITY];
	logic [IW-1:0] link_q  [CAPACITY];
	logic [IW-1:0] size_q, head_q, free_q, cur_q, slot_q, steps_q;
	logic [1:0]    st_q;
	in_item_t      op_q;

	out_item_t  ob_q [2];
	logic       owp_q, orp_q;
	logic [1:0] ocnt_q;
	logic       o_push;
	out_item_t  o_item;
	logic       space;

	logic [IW-1:0] cfg_sz;
	logic [IW-1:0] nx;
	logic          cur_ok, free_ok;

	assign empty     = ocnt_q == 2'd0;
	assign dout      = ob_q[orp_q];
	assign space     = (ocnt_q != 2'd2);
	assign cfg_ready = (st_q == ST_IDLE);
	assign cmd_take  = (st_q == ST_IDLE) && cmd_valid && !cfg_valid && (ocnt_q == 2'd0);

	always_comb begin
		if (cfg_data == 5'd0) cfg_sz = IW'(1);
		else if ({27'd0, cfg_data} > 32'(CAPACITY)) cfg_sz = IW'(CAPACITY);
		else cfg_sz = IW'(cfg_data);
	end

	assign cur_ok  = cur_q < size_q;
	assign nx      = link_q[cur_q[AW-1:0]];
	assign free_ok = free_q < size_q;

	always_comb begin
		o_push = 1'b0;
		o_item = '0;
		unique case (st_q)
			ST_IDLE: begin
				if (cmd_take && (cmd.func == FUNC_INS_HEAD || cmd.func == FUNC_INS_TAIL)) begin
					o_push      = 1'b1;
					o_item.ok   = free_ok;
					o_item.last = 1'b1;
				end
			end
			ST_WALK: begin
				if (op_q.func == FUNC_SEARCH) begin
					if (!cur_ok || steps_q >= size_q) begin
						o_push = 1'b1; o_item.last = 1'b1;
					end else if (float_eq(val_mem[cur_q[AW-1:0]], op_q.value)) begin
						o_push = 1'b1; o_item.ok = 1'b1; o_item.last = 1'b1;
					end
				end
			end
			ST_EMIT: begin
				if (space) begin
					o_push = 1'b1;
					if (!cur_ok) begin
						o_item.last = 1'b1;
					end else begin
						o_item.ok         = 1'b1;
						o_item.item_value = val_mem[cur_q[AW-1:0]];
						o_item.last       = (steps_q + IW'(1) >= size_q) || (nx >= size_q);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (o_push) ob_q[owp_q] <= o_item;
		if (cmd_take && (cmd.func == FUNC_INS_HEAD || cmd.func == FUNC_INS_TAIL) && free_ok) begin
			val_mem[free_q[AW-1:0]] <= cmd.value;
		end
	end

	// Take a command only with the output queue empty so every result fits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= IW'(CAPACITY);
			head_q  <= IW'(CAPACITY);
			free_q  <= '0;
			st_q    <= ST_IDLE;
			cur_q   <= '0;
			slot_q  <= '0;
			steps_q <= '0;
			op_q    <= '0;
			owp_q   <= 1'b0;
			orp_q   <= 1'b0;
			ocnt_q  <= 2'd0;
			for (int i = 0; i < CAPACITY; i++) link_q[i] <= IW'(i + 1);
		end else begin
			if (o_push) owp_q <= ~owp_q;
			if (pop && !empty) orp_q <= ~orp_q;
			ocnt_q <= ocnt_q + {1'b0, o_push} - {1'b0, pop && !empty};
			unique case (st_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						size_q <= cfg_sz;
						head_q <= cfg_sz;
						free_q <= '0;
						for (int i = 0; i < CAPACITY; i++) link_q[i] <= IW'(i + 1);
					end else if (cmd_take) begin
						op_q    <= cmd;
						cur_q   <= head_q;
						steps_q <= '0;
						unique case (cmd.func)
							FUNC_INS_HEAD: begin
								if (free_ok) begin
									free_q <= link_q[free_q[AW-1:0]];
									link_q[free_q[AW-1:0]] <= (head_q < size_q) ? head_q : size_q;
									head_q <= free_q;
								end
							end
							FUNC_INS_TAIL: begin
								if (free_ok) begin
									free_q <= link_q[free_q[AW-1:0]];
									link_q[free_q[AW-1:0]] <= size_q;
									slot_q <= free_q;
									if (head_q >= size_q) head_q <= free_q;
									else st_q <= ST_WALK;
								end
							end
							FUNC_SEARCH: st_q <= ST_WALK;
							FUNC_TRAVERSE: st_q <= ST_EMIT;
							default: ;
						endcase
					end
				end
				ST_WALK: begin
					if (op_q.func == FUNC_INS_TAIL) begin
						if (steps_q >= size_q || nx >= size_q || nx == slot_q) begin
							link_q[cur_q[AW-1:0]] <= slot_q;
							st_q <= ST_IDLE;
						end else begin
							cur_q   <= nx;
							steps_q <= steps_q + IW'(1);
						end
					end else if (o_push) begin
						st_q <= ST_IDLE;
					end else begin
						cur_q   <= nx;
						steps_q <= steps_q + IW'(1);
					end
				end
				ST_EMIT: begin
					if (o_push) begin
						if (o_item.last) st_q <= ST_IDLE;
						cur_q   <= nx;
						steps_q <= steps_q + IW'(1);
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	a_ocnt: assert property (@(posedge clk) disable iff (!arst_n) ocnt_q != 2'd3)
		else $error("result queue overflow");
	a_nocfg: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !cfg_ready)
		else $error("config open while busy");
	a_size: assert property (@(posedge clk) disable iff (!arst_n)
		(size_q >= IW'(1)) && (size_q <= IW'(CAPACITY)))
		else $error("list size out of range");
	a_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> (steps_q <= size_q))
		else $error("walk exceeded list size");
endmodule

[hw/rtl/cursor_linked_list_engine.sv]
// Insert at head: done in the idle state when the command is taken, result next cycle.
// Insert at tail: walks the links from the head to the last node; search: walks to a match or the end.
// Traverse: list_size beats at most, one beat per cycle while the output queue has space.
// Input queue of two items; a command is taken only once the two-beat output queue is empty.
// Reset (arst_n low): list empty, size CAPACITY, free chain 0..CAPACITY-1.
module cursor_linked_list_engine #(
	parameter int CAPACITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  clle_pkg::in_item_t  din,
	output logic                empty,
	input  logic                pop,
	output clle_pkg::out_item_t dout,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [4:0]          cfg_data
);
	import clle_pkg::*;

	logic     cmd_valid, cmd_take;
	in_item_t cmd;

	clle_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .din(din),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
	);

	clle_back #(.CAPACITY(CAPACITY)) u_back (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
		.cmd(cmd), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.empty(empty), .pop(pop), .dout(dout)
	);
endmodule
